// ===== hw/rtl/dde_pkg.sv =====
// Shared types, constants and helper functions for the directional delta block encoder.
package dde_pkg;

    localparam int PIXEL_W = 8;
    localparam int SIZE_W = 7;
    localparam int SUM_W = 20;
    localparam int DELTA_W = 8;
    localparam int DEFAULT_MAX_SIDE = 64;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [PIXEL_W-1:0] PRED_NONE = 8'd128;
    localparam logic signed [DELTA_W:0] DELTA_MAX = 9'sd127;
    localparam logic signed [DELTA_W:0] DELTA_MIN = -9'sd127;

    typedef enum logic [1:0] {
        MODE_LEFT = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DIAG = 2'd2
    } mode_t;

    typedef struct packed {
        logic              func;
        logic [PIXEL_W-1:0] pixel;
        logic [SIZE_W-1:0]  block_rows;
        logic [SIZE_W-1:0]  block_cols;
    } in_item_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DELTA_W-1:0] delta;
        logic                      last_delta;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic out_load;
    } dde_cmd_t;

    typedef struct packed {
        logic produce;
    } dde_status_t;

    function automatic logic [PIXEL_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [PIXEL_W-1:0] d);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W + 1 - PIXEL_W){1'b0}}, d};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    function automatic mode_t choose_mode(input logic [SUM_W-1:0] h,
                                          input logic [SUM_W-1:0] v,
                                          input logic [SUM_W-1:0] d);
        if (h < v) begin
            return (h < d) ? MODE_LEFT : MODE_DIAG;
        end
        return (v < d) ? MODE_UP : MODE_DIAG;
    endfunction

endpackage

// ===== hw/rtl/directional_delta_block_encoder.sv =====
// Top level of the directional delta block encoder: controller, datapath and checks.
// Each accepted transfer passes through three steps: accept, block store read, execute.
// A drain's delta result is loaded into the output register, which drives m_valid, when execute completes.
// The next input is taken once execute finishes; a drain with a result waits in execute
// while an earlier result is still held in the output register.
// Reset (aresetn low at a clock edge) empties the block; store contents are not cleared.
module directional_delta_block_encoder #(
    parameter int MAX_SIDE = dde_pkg::DEFAULT_MAX_SIDE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dde_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dde_pkg::out_item_t m_data
);
    import dde_pkg::*;

    dde_cmd_t    cmd;
    dde_status_t status;

    dde_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .status  (status),
        .cmd     (cmd)
    );

    dde_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (m_data)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input transfer taken while an item is in progress");

    a_load_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (status.produce && cmd.exec))
        else $error("output loaded without a valid drain result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/dde_controller.sv =====
// Sequencing state machine: accepts one transfer, reads the store, then executes.
module dde_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 m_ready,
    output logic                 m_valid,
    input  dde_pkg::dde_status_t status,
    output dde_pkg::dde_cmd_t    cmd
);
    import dde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!status.produce) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.exec     = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/dde_datapath.sv =====
// Datapath: pixel store, position counters, gradient sums and delta computation.
module dde_datapath #(
    parameter int MAX_SIDE = dde_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dde_pkg::in_item_t    in_item,
    input  dde_pkg::dde_cmd_t    cmd,
    output dde_pkg::dde_status_t status,
    output dde_pkg::out_item_t   out_item
);
    import dde_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (int'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    logic [PIXEL_W-1:0] store_mem [DEPTH];
    logic [PIXEL_W-1:0] rd_a_reg, rd_b_reg;

    logic               func_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [SIDE_W-1:0]  rows_reg, rows_next;
    logic [SIDE_W-1:0]  cols_reg, cols_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   loaded_reg, loaded_next;
    logic [CNT_W-1:0]   sent_reg, sent_next;
    logic [SUM_W-1:0]   hsum_reg, hsum_next;
    logic [SUM_W-1:0]   vsum_reg, vsum_next;
    logic [SUM_W-1:0]   dsum_reg, dsum_next;
    logic [PIXEL_W-1:0] left_reg, left_next;
    mode_t              mode_reg, mode_next;
    logic [SIDE_W-1:0]  lrow_reg, lrow_next, lcol_reg, lcol_next;
    logic [SIDE_W-1:0]  drow_reg, drow_next, dcol_reg, dcol_next;
    out_item_t          out_reg;

    logic                     is_drain, load_ok, produce;
    logic [SIDE_W-1:0]        cur_row, cur_col, side;
    logic [CNT_W-1:0]         idx, up_idx, diag_idx, left_idx;
    logic [ADDR_W-1:0]        addr_a, addr_b;
    logic                     row_gt0, col_gt0, diag_en;
    logic [CNT_W-1:0]         loaded_inc, sent_inc;
    logic                     last;
    logic [PIXEL_W-1:0]       pred;
    logic signed [DELTA_W:0]  diff;
    logic signed [DELTA_W-1:0] delta_sat;
    logic [2*SIDE_W-1:0]      product;

    assign is_drain = (func_reg == FUNC_DRAIN);
    assign load_ok  = !is_drain && (loaded_reg < total_reg);
    assign produce  = is_drain && (loaded_reg != '0) && (loaded_reg >= total_reg)
                      && (sent_reg < total_reg);
    assign status.produce = produce;

    assign cur_row  = is_drain ? drow_reg : lrow_reg;
    assign cur_col  = is_drain ? dcol_reg : lcol_reg;
    assign idx      = is_drain ? sent_reg : loaded_reg;
    assign up_idx   = idx - CNT_W'(cols_reg);
    assign diag_idx = up_idx - CNT_W'(1);
    assign left_idx = idx - CNT_W'(1);
    assign row_gt0  = (cur_row != '0);
    assign col_gt0  = (cur_col != '0);
    assign side     = (rows_reg < cols_reg) ? rows_reg : cols_reg;
    assign diag_en  = row_gt0 && col_gt0 && (cur_row < side) && (cur_col < side);
    assign product  = rows_reg * cols_reg;

    always_comb begin
        addr_a = is_drain ? idx[ADDR_W-1:0] : up_idx[ADDR_W-1:0];
        addr_b = diag_idx[ADDR_W-1:0];
        if (is_drain) begin
            case (mode_reg)
                MODE_LEFT: addr_b = left_idx[ADDR_W-1:0];
                MODE_UP:   addr_b = up_idx[ADDR_W-1:0];
                default:   addr_b = diag_idx[ADDR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && load_ok) begin
            store_mem[loaded_reg[ADDR_W-1:0]] <= pixel_reg;
        end
        rd_a_reg <= store_mem[addr_a];
        rd_b_reg <= store_mem[addr_b];
    end

    always_comb begin
        pred = PRED_NONE;
        case (mode_reg)
            MODE_LEFT: if (col_gt0) pred = rd_b_reg;
            MODE_UP:   if (row_gt0) pred = rd_b_reg;
            MODE_DIAG: if (row_gt0 && col_gt0) pred = rd_b_reg;
            default:   pred = PRED_NONE;
        endcase
        diff = $signed({1'b0, rd_a_reg}) - $signed({1'b0, pred});
        if (diff > DELTA_MAX) begin
            delta_sat = DELTA_MAX[DELTA_W-1:0];
        end else if (diff < DELTA_MIN) begin
            delta_sat = DELTA_MIN[DELTA_W-1:0];
        end else begin
            delta_sat = diff[DELTA_W-1:0];
        end
    end

    assign loaded_inc = loaded_reg + CNT_W'(1);
    assign sent_inc   = sent_reg + CNT_W'(1);
    assign last       = (sent_inc == total_reg);

    always_comb begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        loaded_next = loaded_reg;
        sent_next   = sent_reg;
        hsum_next   = hsum_reg;
        vsum_next   = vsum_reg;
        dsum_next   = dsum_reg;
        left_next   = left_reg;
        mode_next   = mode_reg;
        lrow_next   = lrow_reg;
        lcol_next   = lcol_reg;
        drow_next   = drow_reg;
        dcol_next   = dcol_reg;
        if (cmd.accept && (in_item.func == FUNC_LOAD) && (loaded_reg == '0)) begin
            rows_next = clamp_side(in_item.block_rows);
            cols_next = clamp_side(in_item.block_cols);
        end
        if (cmd.exec && load_ok) begin
            if (col_gt0) begin
                hsum_next = sat_add(hsum_reg, abs_diff(pixel_reg, left_reg));
            end
            if (row_gt0) begin
                vsum_next = sat_add(vsum_reg, abs_diff(pixel_reg, rd_a_reg));
            end
            if (diag_en) begin
                dsum_next = sat_add(dsum_reg, abs_diff(pixel_reg, rd_b_reg));
            end
            left_next   = pixel_reg;
            loaded_next = loaded_inc;
            if (lcol_reg + SIDE_W'(1) == cols_reg) begin
                lcol_next = '0;
                lrow_next = lrow_reg + SIDE_W'(1);
            end else begin
                lcol_next = lcol_reg + SIDE_W'(1);
            end
            if (loaded_inc == total_reg) begin
                mode_next = choose_mode(hsum_next, vsum_next, dsum_next);
            end
        end
        if (cmd.exec && produce) begin
            sent_next = sent_inc;
            if (dcol_reg + SIDE_W'(1) == cols_reg) begin
                dcol_next = '0;
                drow_next = drow_reg + SIDE_W'(1);
            end else begin
                dcol_next = dcol_reg + SIDE_W'(1);
            end
            if (last) begin
                loaded_next = '0;
                sent_next   = '0;
                hsum_next   = '0;
                vsum_next   = '0;
                dsum_next   = '0;
                left_next   = '0;
                lrow_next   = '0;
                lcol_next   = '0;
                drow_next   = '0;
                dcol_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= in_item.func;
            pixel_reg <= in_item.pixel;
        end
        if (cmd.out_load) begin
            out_reg.mode       <= mode_reg;
            out_reg.delta      <= delta_sat;
            out_reg.last_delta <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= '0;
            cols_reg   <= '0;
            total_reg  <= '0;
            loaded_reg <= '0;
            sent_reg   <= '0;
            hsum_reg   <= '0;
            vsum_reg   <= '0;
            dsum_reg   <= '0;
            left_reg   <= '0;
            mode_reg   <= MODE_LEFT;
            lrow_reg   <= '0;
            lcol_reg   <= '0;
            drow_reg   <= '0;
            dcol_reg   <= '0;
        end else begin
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            total_reg  <= product[CNT_W-1:0];
            loaded_reg <= loaded_next;
            sent_reg   <= sent_next;
            hsum_reg   <= hsum_next;
            vsum_reg   <= vsum_next;
            dsum_reg   <= dsum_next;
            left_reg   <= left_next;
            mode_reg   <= mode_next;
            lrow_reg   <= lrow_next;
            lcol_reg   <= lcol_next;
            drow_reg   <= drow_next;
            dcol_reg   <= dcol_next;
        end
    end

    assign out_item = out_reg;

endmodule
